### hw/rtl/smsh_pkg.sv
// shared types and constants for the splitmix sequence hash unit
// mixing constants, request command format, mixer and sequencer types
// no dependencies
`default_nettype none

package smsh_pkg;

   // element counter widths
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int COUNT_WIDTH_MAX = 32;
   localparam int COUNT_FIELD_W   = 16;
   localparam int WORD_W          = 64;

   // stream packing
   localparam int REQ_TDATA_W    = 88;
   localparam int RSP_TDATA_W    = 64;
   localparam int WORD_LSB       = 0;
   localparam int USE_PREFIX_BIT = 64;
   localparam int COUNT_LSB      = 65;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // splitmix64 constants, FNV offset seed and shift amounts
   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
   localparam logic [WORD_W-1:0] FNV_SEED     = 64'hcbf2_9ce4_8422_2325;
   localparam int SHIFT_A    = 30;
   localparam int SHIFT_B    = 27;
   localparam int SHIFT_C    = 31;
   localparam int FOLD_SHIFT = 32;
   localparam int IDX_SHL    = 6;
   localparam int IDX_SHR    = 2;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_ELEM  = 1'b1
   } req_kind_type;

   // one classified request handed from front to back
   typedef struct packed {
      req_kind_type               kind;
      logic [WORD_W-1:0]          word;
      logic                       use_prefix;
      logic                       last;
      logic [COUNT_WIDTH_MAX-1:0] value;   // count on start, index on element
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] operand;
   } mix_req_type;

   typedef struct packed {
      logic              ready;
      logic              done;
      logic [WORD_W-1:0] result;
   } mix_rsp_type;

   typedef enum logic {
      MX_IDLE,
      MX_MUL
   } mix_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREFIX,
      BK_COUNT,
      BK_ELEM_MIX,
      BK_ELEM_FOLD,
      BK_FINAL,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

### hw/rtl/smsh_front.sv
// front end: accepts requests, tracks the open sequence and classifies items
// depends on smsh_pkg; feeds smsh_queue
`default_nettype none

module smsh_front #(
   parameter int COUNT_WIDTH = smsh_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [smsh_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                          req_tuser,
   input  wire logic                          q_full,
   output logic                               q_push,
   output smsh_pkg::cmd_type                  q_data
);
   import smsh_pkg::*;

   localparam int CntBits = (COUNT_WIDTH < COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;

   logic                   active_ff, active_in;
   logic [COUNT_WIDTH-1:0] index_ff, index_in;
   logic [COUNT_WIDTH-1:0] expected_ff, expected_in;

   logic                   accept;
   req_kind_type           kind;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH:0]   idx_inc;
   logic                   is_last;

   // request decode
   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign kind       = req_kind_type'(req_tuser);
   assign cnt        = COUNT_WIDTH'(req_tdata[COUNT_LSB +: CntBits]);
   assign idx_inc    = {1'b0, index_ff} + (COUNT_WIDTH+1)'(1);
   assign is_last    = idx_inc >= {1'b0, expected_ff};

   // sequence tracking and command build
   always_comb begin
      active_in   = active_ff;
      index_in    = index_ff;
      expected_in = expected_ff;
      q_push      = 1'b0;
      q_data.kind       = kind;
      q_data.word       = req_tdata[WORD_LSB +: WORD_W];
      q_data.use_prefix = req_tdata[USE_PREFIX_BIT];
      q_data.last       = 1'b0;
      q_data.value      = COUNT_WIDTH_MAX'(cnt);
      if (accept) begin
         if (kind == REQ_START) begin
            index_in    = '0;
            expected_in = cnt;
            active_in   = (cnt != '0);
            q_push      = 1'b1;
         end else if (active_ff) begin
            q_push       = 1'b1;
            q_data.value = COUNT_WIDTH_MAX'(index_ff);
            q_data.last  = is_last;
            index_in     = idx_inc[COUNT_WIDTH-1:0];
            if (is_last) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         index_ff    <= '0;
         expected_ff <= '0;
      end else begin
         active_ff   <= active_in;
         index_ff    <= index_in;
         expected_ff <= expected_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/smsh_queue.sv
// short command queue that decouples the front end from the hash sequencer
// depends on smsh_pkg for the command type and depth
`default_nettype none

module smsh_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire smsh_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output smsh_pkg::cmd_type      pop_data
);
   import smsh_pkg::*;

   localparam int PtrW  = $clog2(QUEUE_DEPTH);
   localparam int FillW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   // status
   assign full      = (fill_ff == FillW'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = FillW'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = FillW'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/smsh_mix.sv
// iterative splitmix64 finalizer on one shared 32x32 multiplier
// depends on smsh_pkg; each 64-bit product takes three partial products
`default_nettype none

module smsh_mix (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire smsh_pkg::mix_req_type mix_req,
   output smsh_pkg::mix_rsp_type     mix_rsp
);
   import smsh_pkg::*;

   localparam logic [1:0] STEP_LO   = 2'd0;
   localparam logic [1:0] STEP_HI_X = 2'd1;
   localparam logic [1:0] STEP_HI_K = 2'd2;

   mix_state_type     state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [1:0]        step_ff, step_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] result_ff, result_in;

   logic [WORD_W-1:0] pre_sum, pre_x, k, product, acc_next;
   logic [31:0]       mul_a, mul_b;

   // datapath: offset, shift-xor and one partial product
   assign pre_sum  = mix_req.operand + GOLDEN_GAMMA;
   assign pre_x    = pre_sum ^ (pre_sum >> SHIFT_A);
   assign k        = phase_ff ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a    = (step_ff == STEP_HI_X) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b    = (step_ff == STEP_HI_K) ? k[63:32] : k[31:0];
   assign product  = {32'b0, mul_a} * {32'b0, mul_b};
   assign acc_next = (step_ff == STEP_LO) ? product
                                          : {acc_ff[63:32] + product[31:0], acc_ff[31:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MX_IDLE: begin
            if (mix_req.start) begin
               state_in = MX_MUL;
            end
         end
         MX_MUL: begin
            if (step_ff == STEP_HI_K && phase_ff) begin
               state_in = MX_IDLE;
            end
         end
         default: state_in = MX_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      phase_in  = phase_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      x_in      = x_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      unique case (state_ff)
         MX_IDLE: begin
            if (mix_req.start) begin
               x_in     = pre_x;
               phase_in = 1'b0;
               step_in  = STEP_LO;
            end
         end
         MX_MUL: begin
            acc_in  = acc_next;
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_HI_K) begin
               step_in = STEP_LO;
               if (!phase_ff) begin
                  x_in     = acc_next ^ (acc_next >> SHIFT_B);
                  phase_in = 1'b1;
               end else begin
                  result_in = acc_next ^ (acc_next >> SHIFT_C);
                  done_in   = 1'b1;
               end
            end
         end
         default: begin
            step_in = STEP_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MX_IDLE;
         phase_ff <= 1'b0;
         step_ff  <= STEP_LO;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign mix_rsp.ready  = (state_ff == MX_IDLE);
   assign mix_rsp.done   = done_ff;
   assign mix_rsp.result = result_ff;

endmodule

`default_nettype wire

### hw/rtl/smsh_back.sv
// back end: sequences the mixes of each command and holds the running hash
// depends on smsh_pkg and smsh_mix; drives the response register
`default_nettype none

module smsh_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   input  wire smsh_pkg::cmd_type             cmd,
   output logic                               cmd_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [smsh_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import smsh_pkg::*;

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [WORD_W-1:0] running_ff, running_in;
   logic [WORD_W-1:0] out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_load;

   mix_req_type       mix_req;
   mix_rsp_type       mix_rsp;
   logic [WORD_W-1:0] idx64, elem_op, res;
   logic              out_free;

   smsh_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .mix_req (mix_req),
      .mix_rsp (mix_rsp)
   );

   // operand sources
   assign idx64    = WORD_W'(cmd.value);
   assign elem_op  = cmd.word + GOLDEN_GAMMA + (idx64 << IDX_SHL) + (idx64 >> IDX_SHR);
   assign res      = mix_rsp.result;
   assign out_free = !out_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && mix_rsp.ready) begin
               if (cmd.kind == REQ_ELEM) begin
                  state_in = BK_ELEM_MIX;
               end else if (cmd.use_prefix) begin
                  state_in = BK_PREFIX;
               end else begin
                  state_in = BK_COUNT;
               end
            end
         end
         BK_PREFIX: begin
            if (mix_rsp.done) begin
               state_in = BK_COUNT;
            end
         end
         BK_COUNT: begin
            if (mix_rsp.done) begin
               state_in = (cmd_ff.value == '0) ? BK_FINAL : BK_IDLE;
            end
         end
         BK_ELEM_MIX: begin
            if (mix_rsp.done) begin
               state_in = BK_ELEM_FOLD;
            end
         end
         BK_ELEM_FOLD: begin
            if (mix_rsp.done) begin
               state_in = cmd_ff.last ? BK_FINAL : BK_IDLE;
            end
         end
         BK_FINAL: begin
            if (mix_rsp.done) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // mixer launches, running hash and response load
   always_comb begin
      cmd_pop         = 1'b0;
      cmd_in          = cmd_ff;
      running_in      = running_ff;
      mix_req.start   = 1'b0;
      mix_req.operand = res;
      out_load        = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && mix_rsp.ready) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd;
               mix_req.start = 1'b1;
               if (cmd.kind == REQ_ELEM) begin
                  mix_req.operand = elem_op;
               end else if (cmd.use_prefix) begin
                  mix_req.operand = FNV_SEED ^ cmd.word;
               end else begin
                  mix_req.operand = FNV_SEED ^ WORD_W'(cmd.value);
               end
            end
         end
         BK_PREFIX: begin
            if (mix_rsp.done) begin
               mix_req.start   = 1'b1;
               mix_req.operand = res ^ WORD_W'(cmd_ff.value);
            end
         end
         BK_COUNT: begin
            if (mix_rsp.done) begin
               running_in      = res;
               mix_req.start   = (cmd_ff.value == '0);
               mix_req.operand = res + GOLDEN_GAMMA;
            end
         end
         BK_ELEM_MIX: begin
            if (mix_rsp.done) begin
               mix_req.start   = 1'b1;
               mix_req.operand = running_ff ^ res;
            end
         end
         BK_ELEM_FOLD: begin
            if (mix_rsp.done) begin
               running_in      = res;
               mix_req.start   = cmd_ff.last;
               mix_req.operand = res + GOLDEN_GAMMA;
            end
         end
         BK_OUT: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // response register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_in       = res ^ (res >> FOLD_SHIFT);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      running_ff <= running_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   // a mix is only launched into an idle mixer
   assert property (@(posedge clock) disable iff (reset)
      mix_req.start |-> mix_rsp.ready)
      else $error("mix launched while mixer busy");

   // a finished mix only arrives while a mix is awaited
   assert property (@(posedge clock) disable iff (reset)
      mix_rsp.done |-> (state_ff != BK_IDLE && state_ff != BK_OUT))
      else $error("mix result with no mix pending");

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_tready))
      else $error("response register overwritten");
`endif

endmodule

`default_nettype wire

### hw/rtl/splitmix_sequence_hash_unit.sv
// top level of the splitmix sequence hash unit
// depends on smsh_pkg, smsh_front, smsh_queue and smsh_back
//
//   req channel: one request per handshake, tuser = kind (0 start, 1 element).
//   a start carries the prefix word, the prefix enable and the element count;
//   an element carries one 64-bit word. elements with no open sequence are
//   dropped; a start abandons any sequence in progress.
//   rsp channel: one 64-bit hash per finished sequence, after the last
//   announced element, or right after a start with a zero count.
//   every mix runs on one shared 32x32 multiplier, three partial products per
//   64-bit multiply, two multiplies per mix.
//   a request is registered in the queue before it reaches the back end.
//   an element holds the back end for two mixes, a start for one or two
//   (without or with prefix); the last adds a final mix and a response load.
//   requests enter at one per cycle into a 2-entry queue and stall only when
//   that queue is full.
//   reset closes any open sequence and empties the queue and response register.
//   while rsp_tready is low the response is held and the back end waits once
//   its next hash is ready; requests keep entering until the queue fills.
`default_nettype none

module splitmix_sequence_hash_unit #(
   parameter int COUNT_WIDTH = smsh_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // word [63:0], use_prefix [64], count [80:65], zero pad [87:81]
   input  wire logic [smsh_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // hash [63:0]
   output logic [smsh_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import smsh_pkg::*;

   logic    q_full, q_push, q_valid, q_pop;
   cmd_type q_in, q_out;

   // front end
   smsh_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   // command queue
   smsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   // hash sequencer
   smsh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_out),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for splitmix_sequence_hash_unit: streams start and element requests,
// predicts each sequence hash and checks every response in order
// depends on smsh_pkg and the splitmix_sequence_hash_unit rtl
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smsh_pkg::req_kind_type;
   import smsh_pkg::REQ_START;
   import smsh_pkg::REQ_ELEM;

   // hashing constants kept locally for the predictor
   localparam logic [63:0] GAMMA      = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MUL_FIRST  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MUL_SECOND = 64'h94d0_49bb_1331_11eb;
   localparam logic [63:0] FNV_OFFSET = 64'hcbf2_9ce4_8422_2325;

   localparam int RANDOM_ITEMS  = 750;
   localparam int RUN_LIMIT     = 300000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 300;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      req_kind_type kind;
      logic [63:0]  word;
      logic         use_prefix;
      logic [15:0]  count;
      bit           hold_for_idle;   // sender waits until all hashes are back
   } hash_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;     // word [63:0], use_prefix [64], count [80:65], pad [87:81]
   logic        req_tuser = 1'b0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // hash [63:0]

   splitmix_sequence_hash_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [63:0] seq_hash  = '0;
   logic [15:0] seq_index = '0;
   logic [15:0] seq_total = '0;
   bit          seq_open  = 1'b0;

   hash_request_type pending_requests[$];
   logic [63:0]      expected_hashes[$];
   hash_request_type current_req;

   int cycle_count       = 0;
   int requests_accepted = 0;
   int starts_accepted   = 0;
   int elements_accepted = 0;
   int hashes_predicted  = 0;
   int hashes_checked    = 0;
   int failures          = 0;
   int hold_cycles       = 0;
   bit hold_fired        = 1'b0;

   // one splitmix64 avalanche round
   function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
      z = z + GAMMA;
      z = (z ^ (z >> 30)) * MUL_FIRST;
      z = (z ^ (z >> 27)) * MUL_SECOND;
      return z ^ (z >> 31);
   endfunction

   // closing avalanche and upper-half fold
   function automatic logic [63:0] seal_hash(input logic [63:0] h);
      h = splitmix_mix(h + GAMMA);
      return h ^ (h >> 32);
   endfunction

   // update the sequence state for one request, queue any finished hash
   task automatic absorb_request(input hash_request_type r, output bit produced);
      logic [63:0] h;
      logic [63:0] idx;
      logic [63:0] folded;
      produced = 1'b0;
      if (r.kind == REQ_START) begin
         h = FNV_OFFSET;
         if (r.use_prefix)
            h = splitmix_mix(h ^ r.word);
         h = splitmix_mix(h ^ {48'd0, r.count});
         seq_hash  = h;
         seq_index = '0;
         seq_total = r.count;
         seq_open  = (r.count != 0);
         if (r.count == 0) begin
            expected_hashes.push_back(seal_hash(h));
            produced = 1'b1;
         end
      end else if (seq_open) begin
         idx = {48'd0, seq_index};
         folded = splitmix_mix(r.word + GAMMA + (idx << 6) + (idx >> 2));
         seq_hash = splitmix_mix(seq_hash ^ folded);
         if (int'(seq_index) + 1 >= int'(seq_total)) begin
            seq_open = 1'b0;
            expected_hashes.push_back(seal_hash(seq_hash));
            produced = 1'b1;
         end
         seq_index = seq_index + 16'd1;
      end
   endtask

   task automatic push_request(input req_kind_type kind, input logic [63:0] word,
                               input logic use_prefix, input logic [15:0] count,
                               input bit hold_for_idle);
      hash_request_type r;
      r.kind          = kind;
      r.word          = word;
      r.use_prefix    = use_prefix;
      r.count         = count;
      r.hold_for_idle = hold_for_idle;
      pending_requests.push_back(r);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic report_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("[%0t] %s", $realtime, what);
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : driver
      bit produced;
      int outstanding;
      static int burst_left = 0;
      static int gap_left   = 0;
      produced = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_request(current_req, produced);
            requests_accepted <= requests_accepted + 1;
            if (current_req.kind == REQ_START)
               starts_accepted <= starts_accepted + 1;
            else
               elements_accepted <= elements_accepted + 1;
            if (produced)
               hashes_predicted <= hashes_predicted + 1;
         end
         outstanding = hashes_predicted + int'(produced) - hashes_checked;
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].hold_for_idle && outstanding != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               current_req = pending_requests.pop_front();
               req_tdata  <= {7'd0, current_req.count, current_req.use_prefix,
                              current_req.word};
               req_tuser  <= current_req.kind;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // one long receiver hold-off once traffic is under way
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (!hold_fired && requests_accepted >= HOLD_AFTER) begin
         hold_cycles <= LONG_HOLD;
         hold_fired  <= 1'b1;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // response monitor with a rotating stall pattern
   always @(posedge clock) begin : monitor
      logic [63:0] want;
      static logic [15:0] stall_pattern = 16'hffff;
      static int pattern_age = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               report_failure($sformatf("unexpected hash %h", rsp_tdata));
            end else begin
               want = expected_hashes.pop_front();
               hashes_checked <= hashes_checked + 1;
               if (rsp_tdata !== want)
                  report_failure($sformatf("hash mismatch: expected %h, got %h",
                                           want, rsp_tdata));
            end
         end
         if (pattern_age == 0) begin
            pattern_age = 50;
            case ($urandom_range(0, 3))
               0: begin
                  stall_pattern = 16'hffff;
               end
               1: begin
                  stall_pattern = 16'($urandom);
               end
               2: begin
                  stall_pattern = 16'($urandom & $urandom);
               end
               default: begin
                  stall_pattern = 16'($urandom | $urandom);
               end
            endcase
         end
         pattern_age--;
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_tready <= (hold_cycles == 0) && stall_pattern[0];
      end
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      while (cycle_count < RUN_LIMIT)
         @(posedge clock);
      $display("splitmix_sequence_hash_unit verification failed");
      $finish;
   end

   // stimulus and end of run
   initial begin : stimulus
      int random_items;
      int total_requests;
      int roll;
      int n;
      int k;
      logic [15:0] c;
      random_items = 0;

      // directed: stray element, empty sequences, field extremes, abandon cases
      push_request(REQ_ELEM, '1, 1'b1, 16'hffff, 1'b0);
      push_request(REQ_START, '0, 1'b0, 16'd0, 1'b0);
      push_request(REQ_START, '1, 1'b1, 16'd0, 1'b0);
      push_request(REQ_START, 64'h0123_4567_89ab_cdef, 1'b1, 16'd1, 1'b0);
      push_request(REQ_ELEM, '1, 1'b1, 16'hffff, 1'b0);
      push_request(REQ_START, 64'h8000_0000_0000_0001, 1'b0, 16'd3, 1'b0);
      push_request(REQ_ELEM, '0, 1'b0, 16'd0, 1'b0);
      push_request(REQ_ELEM, '1, 1'b0, 16'd0, 1'b0);
      push_request(REQ_ELEM, 64'h8000_0000_0000_0000, 1'b1, 16'h5555, 1'b0);
      push_request(REQ_ELEM, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, 16'd0, 1'b0);
      push_request(REQ_START, '1, 1'b1, 16'hffff, 1'b0);
      push_request(REQ_ELEM, 64'h0000_0000_ffff_ffff, 1'b0, 16'd0, 1'b0);
      push_request(REQ_ELEM, 64'hffff_ffff_0000_0000, 1'b0, 16'd0, 1'b0);
      push_request(REQ_START, 64'h5555_5555_5555_5555, 1'b1, 16'h8000, 1'b0);
      push_request(REQ_START, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 16'd2, 1'b0);
      push_request(REQ_ELEM, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 16'haaaa, 1'b0);
      push_request(REQ_ELEM, 64'h5555_5555_5555_5555, 1'b1, 16'h5555, 1'b0);
      push_request(REQ_START, 64'h1, 1'b1, 16'd4, 1'b0);
      push_request(REQ_START, '0, 1'b1, 16'd1, 1'b0);
      push_request(REQ_ELEM, 64'h1, 1'b0, 16'd0, 1'b0);
      push_request(REQ_ELEM, 64'h2, 1'b0, 16'd0, 1'b0);

      // random: mostly complete sequences, some abandoned ones and stray elements
      while (random_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 85 && !(roll >= 75 && roll < 85)) begin
            k = $urandom_range(0, 19);
            if (k == 0)
               n = 0;
            else if (k == 1)
               n = $urandom_range(16, 40);
            else
               n = $urandom_range(1, 6);
            push_request(REQ_START, random_word(), 1'($urandom_range(0, 1)), 16'(n),
                         (roll >= 70));
            for (int i = 0; i < n; i++)
               push_request(REQ_ELEM, random_word(), 1'($urandom_range(0, 1)),
                            16'($urandom), 1'b0);
            random_items += 1 + n;
         end else if (roll < 85) begin
            c = 16'($urandom);
            if (c < 16'd2)
               c = c + 16'd2;
            push_request(REQ_START, random_word(), 1'($urandom_range(0, 1)), c, 1'b0);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
               push_request(REQ_ELEM, random_word(), 1'($urandom_range(0, 1)),
                            16'($urandom), 1'b0);
            random_items += 1 + n;
         end else if (roll < 93) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               push_request(REQ_ELEM, random_word(), 1'($urandom_range(0, 1)),
                            16'($urandom), 1'b0);
            random_items += n;
         end else begin
            n = $urandom_range(1, 4);
            push_request(REQ_START, random_word(), 1'($urandom_range(0, 1)), 16'(n),
                         1'b1);
            for (int i = 0; i < n; i++)
               push_request(REQ_ELEM, random_word(), 1'($urandom_range(0, 1)),
                            16'($urandom), 1'b0);
            random_items += 1 + n;
         end
      end
      total_requests = pending_requests.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait until every request is taken, then until every hash is back
      while (requests_accepted != total_requests)
         @(posedge clock);
      while (hashes_checked != hashes_predicted)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_hashes.size() != 0)
         report_failure($sformatf("%0d hashes never arrived", expected_hashes.size()));

      $display("run covered %0d requests: %0d starts, %0d elements",
               requests_accepted, starts_accepted, elements_accepted);
      $display("%0d sequence hashes compared, %0d failures", hashes_checked, failures);
      if (failures == 0)
         $display("splitmix_sequence_hash_unit verification clean");
      else
         $display("splitmix_sequence_hash_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire
